/* rtl/lru_snapshot_slot_cache_top_assert.svh */
// Assertion macros for the snapshot slot cache top level.
`ifndef LRU_SNAPSHOT_SLOT_CACHE_TOP_ASSERT_SVH
`define LRU_SNAPSHOT_SLOT_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lssc_pkg.sv */
// Types and constants shared by the snapshot slot cache modules.
package lssc_pkg;

	localparam int SLOTS_DEF = 16;
	// Index and count widths sized for the largest supported table (256 entries).
	localparam int IDX_W     = 8;
	localparam int CNT_W     = 9;
	localparam int CTR_W     = 32;
	localparam int KEY_W     = 64;
	localparam int DEPTH_W   = 15;

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_RESTORE = 2'd1,
		ACT_PROBE   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		STAT_INSERTED = 3'd0,
		STAT_CACHED   = 3'd1,
		STAT_HIT      = 3'd2,
		STAT_MISS     = 3'd3,
		STAT_RANGE    = 3'd4,
		STAT_NOROOM   = 3'd5
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	typedef enum logic [1:0] {
		COMMIT_NONE    = 2'd0,
		COMMIT_INSERT  = 2'd1,
		COMMIT_PROMOTE = 2'd2
	} commit_op_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [KEY_W-1:0]   key_hash;
		logic signed [15:0] block_pos;
		logic [7:0]         active_slot;
	} item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic             found;
		logic [3:0]       slot;
		logic             evicted;
		logic [3:0]       evicted_slot;
		logic [7:0]       active_echo;
		logic [CTR_W-1:0] hit_total;
		logic [CTR_W-1:0] miss_total;
		logic [CTR_W-1:0] eviction_total;
		logic [4:0]       occupancy;
	} result_t;

	// Lookup record that walks down the cell chain.
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [IDX_W-1:0] hit_age;
		logic             free;
		logic [IDX_W-1:0] free_idx;
		logic             vict;
		logic [IDX_W-1:0] vict_idx;
		logic [CNT_W-1:0] occ;
	} scan_t;

	// Update broadcast to every cell at the end of a lookup.
	typedef struct packed {
		commit_op_t       op;
		logic [IDX_W-1:0] tgt;
		logic [IDX_W-1:0] age_lim;
	} commit_t;

endpackage

/* rtl/lssc_cell.sv */
// One table entry: tag, valid and age, plus its stage of the lookup chain.
module lssc_cell #(
	parameter int SLOTS = lssc_pkg::SLOTS_DEF,
	parameter int IDX   = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [lssc_pkg::KEY_W-1:0] key,
	input  lssc_pkg::scan_t          scan_in,
	output lssc_pkg::scan_t          scan_out,
	input  lssc_pkg::commit_t        commit
);

	localparam int AGE_W = $clog2(SLOTS);
	localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(SLOTS - 1);
	localparam logic [lssc_pkg::IDX_W-1:0] MY_IDX = lssc_pkg::IDX_W'(IDX);

	logic                       valid_q;
	logic [lssc_pkg::KEY_W-1:0] tag_q;
	logic [AGE_W-1:0]           age_q;
	lssc_pkg::scan_t            scan_q;
	lssc_pkg::scan_t            scan_nxt;
	logic                       is_tgt;

	assign is_tgt   = (commit.tgt == MY_IDX);
	assign scan_out = scan_q;

	always_comb begin
		scan_nxt = scan_in;
		// first valid match wins; tags are only looked at while valid
		if (valid_q && (tag_q == key) && !scan_in.hit) begin
			scan_nxt.hit     = 1'b1;
			scan_nxt.hit_idx = MY_IDX;
			scan_nxt.hit_age = lssc_pkg::IDX_W'(age_q);
		end
		if (!valid_q && !scan_in.free) begin
			scan_nxt.free     = 1'b1;
			scan_nxt.free_idx = MY_IDX;
		end
		// valid ages are distinct, so the oldest has the top age when full
		if (valid_q && (age_q == AGE_MAX)) begin
			scan_nxt.vict     = 1'b1;
			scan_nxt.vict_idx = MY_IDX;
		end
		scan_nxt.occ = scan_in.occ + lssc_pkg::CNT_W'(valid_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			valid_q <= 1'b0;
			age_q   <= '0;
		end else begin
			scan_q <= scan_nxt;
			case (commit.op)
				lssc_pkg::COMMIT_INSERT: begin
					if (is_tgt) begin
						valid_q <= 1'b1;
						age_q   <= '0;
					end else if (valid_q) begin
						age_q <= age_q + AGE_W'(1);
					end
				end
				lssc_pkg::COMMIT_PROMOTE: begin
					if (is_tgt) begin
						age_q <= '0;
					end else if (valid_q && (lssc_pkg::IDX_W'(age_q) < commit.age_lim)) begin
						age_q <= age_q + AGE_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((commit.op == lssc_pkg::COMMIT_INSERT) && is_tgt) begin
			tag_q <= key;
		end
	end

endmodule

/* rtl/lru_snapshot_slot_cache_top.sv */
// Top level of the fully associative LRU snapshot slot cache.
//
// Maps 64-bit prefix hashes to SLOTS snapshot slots with least recently
// used replacement. A transaction is taken when start is high and busy is
// low; its result appears on result for exactly one cycle with done high,
// and the receiver cannot stall it, so it must take it in that cycle.
// Each transaction walks the lookup record down the chain of cells, one
// entry per cycle; after the last cell the table update is committed and
// the result registered. busy drops in the done cycle, so a new transaction
// may start there; a new transaction is not taken before the last is done.
// No clearing pass is needed after reset.
// The block depth limit is to be written through cfg_we/cfg_wdata only while idle; the block does not enforce this.
module lru_snapshot_slot_cache_top #(
	parameter int SLOTS = lssc_pkg::SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  lssc_pkg::item_t              item,
	output logic                         done,
	output lssc_pkg::result_t            result,
	input  logic                         cfg_we,
	input  logic [lssc_pkg::DEPTH_W-1:0] cfg_wdata
);

`include "lru_snapshot_slot_cache_top_assert.svh"

	lssc_pkg::state_t                  state_q;
	lssc_pkg::state_t                  state_nxt;
	lssc_pkg::item_t                   item_q;
	logic [lssc_pkg::DEPTH_W-1:0]      depth_q;
	logic [lssc_pkg::CTR_W-1:0]        hit_q;
	logic [lssc_pkg::CTR_W-1:0]        miss_q;
	logic [lssc_pkg::CTR_W-1:0]        evict_q;
	logic [lssc_pkg::CTR_W-1:0]        hit_nxt;
	logic [lssc_pkg::CTR_W-1:0]        miss_nxt;
	logic [lssc_pkg::CTR_W-1:0]        evict_nxt;
	lssc_pkg::result_t                 result_q;
	lssc_pkg::result_t                 res_d;
	logic                              done_q;
	logic                              accept;
	lssc_pkg::scan_t                   head;
	lssc_pkg::scan_t                   chain [SLOTS+1];
	lssc_pkg::scan_t                   tail;
	lssc_pkg::commit_t                 commit;
	logic [SLOTS-1:0]                  tok;
	logic                              range_ok;
	logic                              grow;
	logic [lssc_pkg::CNT_W-1:0]        occ_after;
	logic [lssc_pkg::KEY_W-1:0]        key_now;

	assign accept = start && !busy;
	assign busy   = (state_q == lssc_pkg::S_SCAN);
	assign done   = done_q;
	assign result = result_q;

	// Cell 0 sees the record in the accept cycle, before item_q is loaded.
	assign key_now = accept ? item.key_hash : item_q.key_hash;

	// Fresh lookup record enters cell 0 on acceptance.
	always_comb begin
		head     = '0;
		head.vld = accept;
	end
	assign chain[0] = head;
	assign tail     = chain[SLOTS];

	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			lssc_cell #(
				.SLOTS(SLOTS),
				.IDX  (gi)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.key     (key_now),
				.scan_in (chain[gi]),
				.scan_out(chain[gi+1]),
				.commit  (commit)
			);
			assign tok[gi] = chain[gi+1].vld;
		end
	endgenerate

	// FSM: idle until a transaction is taken, then wait for the record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lssc_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lssc_pkg::S_IDLE: begin
				if (start) state_nxt = lssc_pkg::S_SCAN;
			end
			lssc_pkg::S_SCAN: begin
				if (tail.vld) state_nxt = lssc_pkg::S_IDLE;
			end
			default: state_nxt = lssc_pkg::S_IDLE;
		endcase
	end

	// Insert is allowed for 0 <= block < depth limit.
	assign range_ok = !item_q.block_pos[15] && (item_q.block_pos[14:0] < depth_q);
	assign grow     = (commit.op == lssc_pkg::COMMIT_INSERT) && !res_d.evicted;
	assign occ_after = tail.occ + lssc_pkg::CNT_W'(grow);

	// Decision once the record leaves the last cell.
	always_comb begin
		res_d             = '0;
		res_d.active_echo = item_q.active_slot;
		commit            = '0;
		commit.op         = lssc_pkg::COMMIT_NONE;
		hit_nxt           = hit_q;
		miss_nxt          = miss_q;
		evict_nxt         = evict_q;
		case (item_q.action)
			lssc_pkg::ACT_INSERT: begin
				if (!range_ok) begin
					res_d.status = lssc_pkg::STAT_RANGE;
					res_d.found  = tail.hit;
					res_d.slot   = tail.hit ? tail.hit_idx[3:0] : 4'd0;
				end else if (tail.hit) begin
					res_d.status = lssc_pkg::STAT_CACHED;
					res_d.found  = 1'b1;
					res_d.slot   = tail.hit_idx[3:0];
				end else if (tail.free) begin
					res_d.status = lssc_pkg::STAT_INSERTED;
					res_d.found  = 1'b1;
					res_d.slot   = tail.free_idx[3:0];
					commit.op    = lssc_pkg::COMMIT_INSERT;
					commit.tgt   = tail.free_idx;
				end else if (tail.vict) begin
					// full: reuse the oldest entry's slot
					res_d.status       = lssc_pkg::STAT_INSERTED;
					res_d.found        = 1'b1;
					res_d.slot         = tail.vict_idx[3:0];
					res_d.evicted      = 1'b1;
					res_d.evicted_slot = tail.vict_idx[3:0];
					commit.op          = lssc_pkg::COMMIT_INSERT;
					commit.tgt         = tail.vict_idx;
					evict_nxt = (evict_q == '1) ? evict_q : evict_q + lssc_pkg::CTR_W'(1);
				end else begin
					res_d.status = lssc_pkg::STAT_NOROOM;
				end
			end
			lssc_pkg::ACT_RESTORE: begin
				if (tail.hit) begin
					res_d.status   = lssc_pkg::STAT_HIT;
					res_d.found    = 1'b1;
					res_d.slot     = tail.hit_idx[3:0];
					commit.op      = lssc_pkg::COMMIT_PROMOTE;
					commit.tgt     = tail.hit_idx;
					commit.age_lim = tail.hit_age;
					hit_nxt = (hit_q == '1) ? hit_q : hit_q + lssc_pkg::CTR_W'(1);
				end else begin
					res_d.status = lssc_pkg::STAT_MISS;
					miss_nxt = (miss_q == '1) ? miss_q : miss_q + lssc_pkg::CTR_W'(1);
				end
			end
			default: begin
				// probe, and the unused code behaves as a probe
				if (tail.hit) begin
					res_d.status = lssc_pkg::STAT_HIT;
					res_d.found  = 1'b1;
					res_d.slot   = tail.hit_idx[3:0];
				end else begin
					res_d.status = lssc_pkg::STAT_MISS;
				end
			end
		endcase
		if (!tail.vld) commit.op = lssc_pkg::COMMIT_NONE;
		res_d.hit_total      = hit_nxt;
		res_d.miss_total     = miss_nxt;
		res_d.eviction_total = evict_nxt;
		res_d.occupancy      = occ_after[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= lssc_pkg::DEPTH_W'(1);
			hit_q   <= '0;
			miss_q  <= '0;
			evict_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) depth_q <= cfg_wdata;
			done_q <= tail.vld;
			if (tail.vld) begin
				hit_q   <= hit_nxt;
				miss_q  <= miss_nxt;
				evict_q <= evict_nxt;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (accept) item_q <= item;
		if (tail.vld) result_q <= res_d;
	end

	// Only one lookup record may be in the chain at a time.
	`LSSC_ASSERT_NOW(a_one_token, clk, arst_n, 1'b1, $onehot0(tok), "more than one record in chain")
	// A taken transaction holds the block busy in the next cycle.
	`LSSC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, busy, "not busy after accept")
	// The result cycle is an idle cycle.
	`LSSC_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "busy while result shown")
	// Only a successful insert can report an eviction.
	`LSSC_ASSERT_NOW(a_evict_insert, clk, arst_n, done && result.evicted,
		(result.status == lssc_pkg::STAT_INSERTED) && result.found, "eviction without insert")

endmodule
